>>> rtl/prr_pkg.sv
package prr_pkg;

  localparam int SLOTS_DEF      = 8;
  localparam int SLOT_BYTES_DEF = 1500;

  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int IP_W   = 32;
  localparam int PORT_W = 16;
  localparam int SEL_W  = 3;
  localparam int OFS_W  = 11;
  localparam int LEN_W  = 11;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_READ = 2'd2
  } op_t;

  // Decoded command, qualified by acc (transfer on the input channel).
  typedef struct packed {
    logic acc;
    logic push;
    logic pop;
    logic rd;
    logic byte_valid;
    logic last;
  } prr_cmd_t;

endpackage

>>> rtl/prr_if.sv
interface prr_in_if
  import prr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] data_byte;
  logic              byte_valid;
  logic              last;
  logic [IP_W-1:0]   src_ip;
  logic [IP_W-1:0]   dst_ip;
  logic [PORT_W-1:0] sport;
  logic [PORT_W-1:0] dport;
  logic [SEL_W-1:0]  slot_sel;
  logic [OFS_W-1:0]  byte_offset;

  modport source (
    output valid, op, data_byte, byte_valid, last, src_ip, dst_ip, sport, dport,
           slot_sel, byte_offset,
    input  ready
  );
  modport sink (
    input  valid, op, data_byte, byte_valid, last, src_ip, dst_ip, sport, dport,
           slot_sel, byte_offset,
    output ready
  );
endinterface

interface prr_out_if
  import prr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              empty_res;
  logic [SEL_W-1:0]  slot_out;
  logic [LEN_W-1:0]  length_out;
  logic [IP_W-1:0]   src_ip_out;
  logic [IP_W-1:0]   dst_ip_out;
  logic [PORT_W-1:0] sport_out;
  logic [PORT_W-1:0] dport_out;
  logic [BYTE_W-1:0] read_byte;

  modport source (
    output valid, empty_res, slot_out, length_out, src_ip_out, dst_ip_out, sport_out,
           dport_out, read_byte,
    input  ready
  );
  modport sink (
    input  valid, empty_res, slot_out, length_out, src_ip_out, dst_ip_out, sport_out,
           dport_out, read_byte,
    output ready
  );
endinterface

>>> rtl/prr_meta.sv
module prr_meta
  import prr_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int SLOT_BYTES = SLOT_BYTES_DEF,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int BW = $clog2(SLOT_BYTES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  prr_cmd_t          cmd,
  input  logic [IP_W-1:0]   src_ip,
  input  logic [IP_W-1:0]   dst_ip,
  input  logic [PORT_W-1:0] sport,
  input  logic [PORT_W-1:0] dport,
  output logic              wr_en,
  output logic [IW-1:0]     wr_slot,
  output logic [BW-1:0]     wr_ofs,
  output logic              empty_res,
  output logic [SEL_W-1:0]  slot_out,
  output logic [LEN_W-1:0]  length_out,
  output logic [IP_W-1:0]   src_ip_out,
  output logic [IP_W-1:0]   dst_ip_out,
  output logic [PORT_W-1:0] sport_out,
  output logic [PORT_W-1:0] dport_out
);

  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
  localparam logic [BW-1:0] FULL_CNT  = BW'(SLOT_BYTES);

  logic [IW-1:0]     widx_r, widx_nxt;
  logic [IW-1:0]     ridx_r, ridx_nxt;
  logic [BW-1:0]     taken_r, taken_nxt;
  logic [BW-1:0]     taken_inc;
  logic [BW-1:0]     len_r     [SLOTS];
  logic [IP_W-1:0]   sip_r     [SLOTS];
  logic [IP_W-1:0]   dip_r     [SLOTS];
  logic [PORT_W-1:0] sport_r   [SLOTS];
  logic [PORT_W-1:0] dport_r   [SLOTS];
  logic              is_empty;
  logic              commit;
  logic              pop_hit;

  logic              empty_r;
  logic [SEL_W-1:0]  slot_r;
  logic [LEN_W-1:0]  length_r;
  logic [IP_W-1:0]   sip_out_r;
  logic [IP_W-1:0]   dip_out_r;
  logic [PORT_W-1:0] sport_out_r;
  logic [PORT_W-1:0] dport_out_r;

  assign is_empty  = (ridx_r == widx_r);
  assign wr_en     = cmd.acc && cmd.push && cmd.byte_valid && (taken_r < FULL_CNT);
  assign wr_slot   = widx_r;
  assign wr_ofs    = taken_r;
  assign taken_inc = wr_en ? taken_r + 1'b1 : taken_r;
  assign commit    = cmd.acc && cmd.push && cmd.last;
  assign pop_hit   = cmd.acc && cmd.pop && !is_empty;

  always_comb begin
    widx_nxt  = widx_r;
    ridx_nxt  = ridx_r;
    taken_nxt = taken_r;
    if (cmd.acc && cmd.push) begin
      taken_nxt = taken_inc;
    end
    if (commit) begin
      widx_nxt  = (widx_r == LAST_SLOT) ? '0 : widx_r + 1'b1;
      taken_nxt = '0;
    end
    if (pop_hit) begin
      ridx_nxt = (ridx_r == LAST_SLOT) ? '0 : ridx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r  <= '0;
      ridx_r  <= '0;
      taken_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        len_r[i]   <= '0;
        sip_r[i]   <= '0;
        dip_r[i]   <= '0;
        sport_r[i] <= '0;
        dport_r[i] <= '0;
      end
    end else begin
      widx_r  <= widx_nxt;
      ridx_r  <= ridx_nxt;
      taken_r <= taken_nxt;
      if (commit) begin
        len_r[widx_r]   <= taken_inc;
        sip_r[widx_r]   <= src_ip;
        dip_r[widx_r]   <= dst_ip;
        sport_r[widx_r] <= sport;
        dport_r[widx_r] <= dport;
      end
    end
  end

  // Outputs zero unless a pop found a packet; empty_res set on empty pop.
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      empty_r     <= cmd.pop && is_empty;
      slot_r      <= pop_hit ? SEL_W'(ridx_r) : '0;
      length_r    <= pop_hit ? LEN_W'(len_r[ridx_r]) : '0;
      sip_out_r   <= pop_hit ? sip_r[ridx_r] : '0;
      dip_out_r   <= pop_hit ? dip_r[ridx_r] : '0;
      sport_out_r <= pop_hit ? sport_r[ridx_r] : '0;
      dport_out_r <= pop_hit ? dport_r[ridx_r] : '0;
    end
  end

  assign empty_res  = empty_r;
  assign slot_out   = slot_r;
  assign length_out = length_r;
  assign src_ip_out = sip_out_r;
  assign dst_ip_out = dip_out_r;
  assign sport_out  = sport_out_r;
  assign dport_out  = dport_out_r;

endmodule

>>> rtl/prr_payload.sv
module prr_payload
  import prr_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int SLOT_BYTES = SLOT_BYTES_DEF,
  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int BW    = $clog2(SLOT_BYTES + 1),
  localparam int DEPTH = SLOTS * SLOT_BYTES,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic              wr_en,
  input  logic [IW-1:0]     wr_slot,
  input  logic [BW-1:0]     wr_ofs,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              rd_req,
  input  logic [SEL_W-1:0]  rd_slot,
  input  logic [OFS_W-1:0]  rd_ofs,
  output logic [BYTE_W-1:0] read_byte
);

  logic [BYTE_W-1:0] mem_r [DEPTH];
  logic [BYTE_W-1:0] rdata_r;
  logic              rd_ok_r;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              rd_hit;

  assign wr_addr = AW'(AW'(wr_slot) * AW'(SLOT_BYTES)) + AW'(wr_ofs);
  assign rd_addr = AW'(AW'(rd_slot) * AW'(SLOT_BYTES)) + AW'(rd_ofs);
  assign rd_hit  = rd_req && (32'(rd_slot) < SLOTS) && (32'(rd_ofs) < SLOT_BYTES);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wdata;
    end
    if (rd_hit) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r <= 1'b0;
    end else if (acc) begin
      rd_ok_r <= rd_hit;
    end
  end

  assign read_byte = rd_ok_r ? rdata_r : '0;

endmodule

>>> rtl/packet_receive_ring.sv
// Channel | Dir | Fields
// in_ch   | in  | op, data_byte, byte_valid, last, src_ip, dst_ip, sport, dport,
//         |     | slot_sel, byte_offset
// out_ch  | out | empty_res, slot_out, length_out, src_ip_out, dst_ip_out, sport_out,
//         |     | dport_out, read_byte
//
// One result per input transfer, registered and presented in the next cycle; one transfer per cycle
// while out_ch.ready is high.
// Synchronous active-low reset clears indices, byte count and slot metadata;
// payload RAM is not cleared, so no clearing pass is needed.
// A stalled result holds the output register; the input is taken again as
// soon as that result is transferred.
module packet_receive_ring
  import prr_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int SLOT_BYTES = SLOT_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  prr_in_if.sink     in_ch,
  prr_out_if.source  out_ch
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BW = $clog2(SLOT_BYTES + 1);

  prr_cmd_t      cmd;
  logic          in_ready;
  logic          out_valid_r, out_valid_nxt;
  logic          wr_en;
  logic [IW-1:0] wr_slot;
  logic [BW-1:0] wr_ofs;

  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;

  always_comb begin
    cmd            = '0;
    cmd.acc        = in_ch.valid && in_ready;
    cmd.byte_valid = in_ch.byte_valid;
    cmd.last       = in_ch.last;
    case (op_t'(in_ch.op))
      OP_PUSH: cmd.push = 1'b1;
      OP_POP:  cmd.pop  = 1'b1;
      OP_READ: cmd.rd   = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;

  prr_meta #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_meta (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .src_ip     (in_ch.src_ip),
    .dst_ip     (in_ch.dst_ip),
    .sport      (in_ch.sport),
    .dport      (in_ch.dport),
    .wr_en      (wr_en),
    .wr_slot    (wr_slot),
    .wr_ofs     (wr_ofs),
    .empty_res  (out_ch.empty_res),
    .slot_out   (out_ch.slot_out),
    .length_out (out_ch.length_out),
    .src_ip_out (out_ch.src_ip_out),
    .dst_ip_out (out_ch.dst_ip_out),
    .sport_out  (out_ch.sport_out),
    .dport_out  (out_ch.dport_out)
  );

  prr_payload #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_payload (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (cmd.acc),
    .wr_en     (wr_en),
    .wr_slot   (wr_slot),
    .wr_ofs    (wr_ofs),
    .wdata     (in_ch.data_byte),
    .rd_req    (cmd.acc && cmd.rd),
    .rd_slot   (in_ch.slot_sel),
    .rd_ofs    (in_ch.byte_offset),
    .read_byte (out_ch.read_byte)
  );

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |=> out_valid_r)
    else $error("transfer in gave no result");

  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.empty_res |->
      (out_ch.length_out == '0) && (out_ch.read_byte == '0) && (out_ch.slot_out == '0))
    else $error("empty pop carries data");

  a_read_no_meta: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_ch.read_byte != '0) |->
      !out_ch.empty_res && (out_ch.length_out == '0) && (out_ch.src_ip_out == '0))
    else $error("read result carries metadata");

  a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (32'(wr_ofs) < SLOT_BYTES) && (32'(wr_slot) < SLOTS))
    else $error("payload write outside slot");

endmodule
